// ----- src/pmrl_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the per-meter runaway limiter.
// No dependencies.
package pmrl_pkg;

  localparam logic [1:0] ACT_SEND    = 2'd0;
  localparam logic [1:0] ACT_RUNAWAY = 2'd1;
  localparam logic [1:0] ACT_SILENT  = 2'd2;

  localparam logic [1:0] REG_LIMIT   = 2'd0;
  localparam logic [1:0] REG_WINDOW  = 2'd1;
  localparam logic [1:0] REG_LOCKOUT = 2'd2;

  localparam logic [7:0]  LIMIT_RESET   = 8'd10;
  localparam logic [15:0] WINDOW_RESET  = 16'd1;
  localparam logic [15:0] LOCKOUT_RESET = 16'd60;

  typedef struct packed {
    logic [31:0] start;
    logic [8:0]  count;
  } entry_t;

endpackage

// ----- src/pmrl_table.sv -----
`timescale 1ns / 1ps
// Meter table: entry memory with registered read and per-entry valid flops.
// Depends on pmrl_pkg.
module pmrl_table
  import pmrl_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic                     rd_valid,
  output entry_t                   rd_entry,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  entry_t                   wr_entry
);

  entry_t           mem [DEPTH];
  logic [DEPTH-1:0] valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_entry <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      rd_valid <= valid[rd_addr];
    end
  end

endmodule

// ----- src/per_meter_runaway_limiter.sv -----
`timescale 1ns / 1ps
// Per-meter runaway limiter: top level with sequencer and shared multiplier.
// Depends on pmrl_pkg and pmrl_table.
// An accepted item passes the READ, WIN and LOCK states; done is raised as LOCK
// is left (as READ is left for a meter outside the table). Busy holds off new
// items over the table read-modify-write and one multiplier shared by the window
// and lockout thresholds. Reset clears all valid bits, loads the register defaults.
module per_meter_runaway_limiter
  import pmrl_pkg::*;
#(
  parameter int TABLE_DEPTH   = 256,
  parameter int MS_PER_MINUTE = 60000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  meter_id,
  input  logic [31:0] now_ms,
  output logic        done,
  output logic [1:0]  action,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int MEM_DEPTH = (TABLE_DEPTH < 256) ? TABLE_DEPTH : 256;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam logic [15:0] MS_MIN = 16'(MS_PER_MINUTE);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_WIN, S_LOCK} state_t;

  state_t      state;
  logic [7:0]  runaway_limit;
  logic [15:0] window_minutes;
  logic [15:0] lockout_minutes;
  logic [7:0]  id_q;
  logic [31:0] now_q;
  logic [31:0] thr;
  logic [31:0] elapsed_q;
  logic [31:0] start_q;
  logic [8:0]  count_q;

  logic               accept;
  logic               in_range;
  logic [ADDR_W-1:0]  addr;
  logic               rd_valid;
  entry_t             rd_entry;
  logic               wr_en;
  entry_t             wr_entry;
  logic [15:0]        mul_a;
  logic [31:0]        product;
  logic [31:0]        start_v;
  logic [8:0]         count_v;
  logic [31:0]        elapsed;
  logic               win_hit;
  logic               lock_hit;
  logic [8:0]         count_l;
  logic [8:0]         count_next;
  logic [8:0]         limit9;
  logic [1:0]         act_next;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign in_range  = (32'(id_q) < 32'(TABLE_DEPTH));
  assign addr      = ADDR_W'(id_q);
  assign limit9    = {1'b0, runaway_limit};

  assign mul_a   = (state == S_WIN) ? lockout_minutes : window_minutes;
  assign product = 32'(mul_a) * 32'(MS_MIN);

  assign start_v = rd_valid ? rd_entry.start : now_q;
  assign count_v = rd_valid ? rd_entry.count : 9'd0;
  assign elapsed = now_q - start_v;
  assign win_hit = (elapsed >= thr) && (count_v < limit9);

  assign lock_hit   = (elapsed_q >= thr);
  assign count_l    = lock_hit ? 9'd0 : count_q;
  assign count_next = (count_l < limit9 + 9'd1) ? count_l + 9'd1 : count_l;

  always_comb begin
    if (count_next < limit9) begin
      act_next = ACT_SEND;
    end else if (count_next == limit9) begin
      act_next = ACT_RUNAWAY;
    end else begin
      act_next = ACT_SILENT;
    end
  end

  assign wr_en          = (state == S_LOCK);
  assign wr_entry.start = lock_hit ? now_q : start_q;
  assign wr_entry.count = count_next;

  pmrl_table #(
    .DEPTH(MEM_DEPTH)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (addr),
    .rd_valid (rd_valid),
    .rd_entry (rd_entry),
    .wr_en    (wr_en),
    .wr_addr  (addr),
    .wr_entry (wr_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      runaway_limit   <= LIMIT_RESET;
      window_minutes  <= WINDOW_RESET;
      lockout_minutes <= LOCKOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LIMIT:   runaway_limit   <= cfg_data[7:0];
        REG_WINDOW:  window_minutes  <= cfg_data;
        REG_LOCKOUT: lockout_minutes <= cfg_data;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      action <= ACT_SEND;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            id_q  <= meter_id;
            now_q <= now_ms;
            state <= S_READ;
          end
        end
        S_READ: begin
          thr <= product;
          if (in_range) begin
            state <= S_WIN;
          end else begin
            done   <= 1'b1;
            action <= ACT_SEND;
            state  <= S_IDLE;
          end
        end
        S_WIN: begin
          thr       <= product;
          elapsed_q <= win_hit ? 32'd0 : elapsed;
          start_q   <= win_hit ? now_q : start_v;
          count_q   <= win_hit ? 9'd0 : count_v;
          state     <= S_LOCK;
        end
        S_LOCK: begin
          done   <= 1'b1;
          action <= act_next;
          state  <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_out_of_table: assert property (@(posedge clk) disable iff (rst)
    accept && (32'(meter_id) >= 32'(TABLE_DEPTH)) |-> ##2 (done && action == ACT_SEND))
    else $error("meter outside table did not answer send");

  a_in_table_latency: assert property (@(posedge clk) disable iff (rst)
    accept && (32'(meter_id) < 32'(TABLE_DEPTH)) |-> ##4 done)
    else $error("table item did not finish in four cycles");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without an item in flight");

  a_count_saturates: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (wr_entry.count <= 9'd256) && (wr_entry.count != 9'd0))
    else $error("stored count out of range");

endmodule
